// ----- sv/tsbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbm_pkg
// Shared types and constants for the two-sphere bounding merge pipeline.
// ----------------------------------------------------------------------------
package tsbm_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int MAG_W   = 33;
  localparam int SQ_W    = 66;
  localparam int SUM_W   = 68;
  localparam int ROOT_W  = 34;
  localparam int REM_W   = 36;
  localparam int QUO_W   = 33;
  localparam int DIVR_W  = 35;
  localparam int DREM_W  = 35;
  localparam int PROD_W  = 64;
  localparam int NUM_AX  = 3;

  typedef enum logic [1:0] {
    CASE_FIRST  = 2'd0,
    CASE_SECOND = 2'd1,
    CASE_MERGE  = 2'd2
  } merge_case_t;

  typedef struct packed {
    logic [NUM_AX-1:0][COORD_W-1:0] p;
    logic [NUM_AX-1:0][COORD_W-1:0] q;
    logic [RAD_W-1:0]               r1;
    logic [RAD_W-1:0]               r2;
    logic [NUM_AX-1:0][MAG_W-1:0]   mag;
    logic [NUM_AX-1:0]              vneg;
  } pair_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
    pair_t             pair;
  } root_t;

  typedef struct packed {
    logic [NUM_AX-1:0][COORD_W-1:0] center;
    logic [RAD_W-1:0]               radius;
    merge_case_t                    mcase;
    logic [NUM_AX-1:0]              neg;
  } base_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QUO_W-1:0]  num;
    logic [QUO_W-1:0]  quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NUM_AX-1:0] lane;
    logic [DIVR_W-1:0]      divisor;
    base_t                  base;
  } div_t;

  function automatic logic [MAG_W-1:0] sext33(input logic [COORD_W-1:0] a);
    sext33 = {a[COORD_W-1], a};
  endfunction

endpackage

// ----- sv/tsbm_root_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbm_root_cell
// One digit of a restoring square root: brings in two radicand bits, tries
// the next root bit and passes the partial result to the next cell.
// ----------------------------------------------------------------------------
module tsbm_root_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsbm_pkg::root_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tsbm_pkg::root_t out_data
);
  import tsbm_pkg::*;

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             take;
  root_t            nxt;

  always_comb begin
    cur   = {in_data.rem, in_data.rad[SUM_W-1 -: 2]};
    trial = {2'b00, in_data.root, 2'b01};
    diff  = cur - trial;
    take  = (cur >= trial);
    nxt   = in_data;
    nxt.rad  = {in_data.rad[SUM_W-3:0], 2'b00};
    nxt.rem  = take ? diff[REM_W-1:0] : cur[REM_W-1:0];
    nxt.root = {in_data.root[ROOT_W-2:0], take};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

// ----- sv/tsbm_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbm_div_cell
// One quotient bit of a restoring division, for all three axes at once,
// against the shared divisor 2d.
// ----------------------------------------------------------------------------
module tsbm_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tsbm_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tsbm_pkg::div_t out_data
);
  import tsbm_pkg::*;

  logic [DREM_W:0] cur  [NUM_AX];
  logic [DREM_W:0] diff [NUM_AX];
  logic            take [NUM_AX];
  div_t            nxt;

  always_comb begin
    nxt = in_data;
    for (int i = 0; i < NUM_AX; i++) begin
      cur[i]  = {in_data.lane[i].rem, in_data.lane[i].num[QUO_W-1]};
      diff[i] = cur[i] - {1'b0, in_data.divisor};
      take[i] = (cur[i] >= {1'b0, in_data.divisor});
      nxt.lane[i].rem = take[i] ? diff[i][DREM_W-1:0] : cur[i][DREM_W-1:0];
      nxt.lane[i].num = {in_data.lane[i].num[QUO_W-2:0], 1'b0};
      nxt.lane[i].quo = {in_data.lane[i].quo[QUO_W-2:0], take[i]};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

// ----- sv/two_sphere_bounding_merge_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sphere_bounding_merge_unit
// Smallest sphere enclosing two spheres, Q16.16, one pair per cycle unless stalled.
// Pipeline: 3 setup stages, 34 root cells, decision and multiply stages,
// 33 divider cells and an output stage, from input transfer to m_tvalid.
// Throughput: one pair per cycle; each stage holds only while its successor
// is full and stalled. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module two_sphere_bounding_merge_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_center_x/y/z, first_radius, second_center_x/y/z, second_radius
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // merged_center_x/y/z, merged_radius, zero pad
  output logic [127:0] m_tdata,
  // merge_case
  output logic [1:0]   m_tuser
);
  import tsbm_pkg::*;

  localparam int ROOT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = QUO_W;

  // ---------------- stage 1: unpack and center differences ----------------
  pair_t pair_in;
  pair_t s1_data;
  logic  s1_valid, s1_ready;
  logic [MAG_W-1:0] dv [NUM_AX];

  always_comb begin
    pair_in.p[0] = s_tdata[31:0];
    pair_in.p[1] = s_tdata[63:32];
    pair_in.p[2] = s_tdata[95:64];
    pair_in.r1   = s_tdata[126:96];
    pair_in.q[0] = s_tdata[158:127];
    pair_in.q[1] = s_tdata[190:159];
    pair_in.q[2] = s_tdata[222:191];
    pair_in.r2   = s_tdata[253:223];
    for (int i = 0; i < NUM_AX; i++) begin
      dv[i] = sext33(pair_in.q[i]) - sext33(pair_in.p[i]);
      pair_in.vneg[i] = dv[i][MAG_W-1];
      pair_in.mag[i]  = dv[i][MAG_W-1] ? (~dv[i] + 1'b1) : dv[i];
    end
  end

  // ---------------- stage 2: squares ----------------
  pair_t s2_pair;
  logic [SQ_W-1:0] s2_sq [NUM_AX];
  logic s2_valid, s2_ready;

  // ---------------- stage 3: sum of squares, root seed ----------------
  root_t s3_data;
  logic  s3_valid, s3_ready;

  // ---------------- root chain ----------------
  root_t rc_data  [ROOT_CELLS+1];
  logic  rc_valid [ROOT_CELLS+1];
  logic  rc_ready [ROOT_CELLS+1];

  // ---------------- decision and multiply ----------------
  logic         sd_valid, sd_ready;
  base_t        sd_base;
  logic [NUM_AX-1:0][MAG_W-1:0] sd_mag;
  logic [RAD_W-1:0]  sd_drmag;
  logic [ROOT_W-1:0] sd_d;

  div_t  sm_data;
  logic  sm_valid, sm_ready;

  // ---------------- divider chain ----------------
  div_t  dc_data  [DIV_CELLS+1];
  logic  dc_valid [DIV_CELLS+1];
  logic  dc_ready [DIV_CELLS+1];

  logic  sf_ready;

  assign s_tready = s1_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign rc_ready[ROOT_CELLS] = sd_ready;
  assign sd_ready = !sd_valid || sm_ready;
  assign sm_ready = !sm_valid || dc_ready[0];
  assign dc_ready[DIV_CELLS] = sf_ready;
  assign sf_ready = !m_tvalid || m_tready;

  // s3 sits in front of root cell 0; its ready is built from rc_ready[0] of that cell
  assign s3_ready    = !s3_valid || rc_ready[0];
  assign rc_data[0]  = s3_data;
  assign rc_valid[0] = s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      sd_valid <= 1'b0;
      sm_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= s_tvalid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (sd_ready) sd_valid <= rc_valid[ROOT_CELLS];
      if (sm_ready) sm_valid <= sd_valid;
      if (sf_ready) m_tvalid <= dc_valid[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_data <= pair_in;
    end
    if (s2_ready) begin
      s2_pair <= s1_data;
      for (int i = 0; i < NUM_AX; i++) begin
        s2_sq[i] <= s1_data.mag[i] * s1_data.mag[i];
      end
    end
    if (s3_ready) begin
      s3_data.rem  <= '0;
      s3_data.root <= '0;
      s3_data.rad  <= SUM_W'(s2_sq[0]) + SUM_W'(s2_sq[1]) + SUM_W'(s2_sq[2]);
      s3_data.pair <= s2_pair;
    end
  end

  for (genvar k = 0; k < ROOT_CELLS; k++) begin : g_root
    tsbm_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rc_valid[k]),
      .in_ready  (rc_ready[k]),
      .in_data   (rc_data[k]),
      .out_valid (rc_valid[k+1]),
      .out_ready (rc_ready[k+1]),
      .out_data  (rc_data[k+1])
    );
  end

  // decision: containment tests, midpoint, merged radius
  root_t rt;
  logic [ROOT_W:0]   d_r1, d_r2;
  logic              c1, c2, first;
  logic [MAG_W-1:0]  psum [NUM_AX];
  logic [ROOT_W+1:0] rsum;
  logic              drneg;
  base_t             base_next;

  always_comb begin
    rt    = rc_data[ROOT_CELLS];
    d_r1  = (ROOT_W+1)'(rt.root) + (ROOT_W+1)'(rt.pair.r1);
    d_r2  = (ROOT_W+1)'(rt.root) + (ROOT_W+1)'(rt.pair.r2);
    c1    = (ROOT_W+1)'(rt.pair.r1) > d_r2;
    c2    = (ROOT_W+1)'(rt.pair.r2) > d_r1;
    first = c1 || (!c2 && (rt.root == '0));
    rsum  = (ROOT_W+2)'(rt.root) + (ROOT_W+2)'(rt.pair.r1) + (ROOT_W+2)'(rt.pair.r2);
    drneg = rt.pair.r1 > rt.pair.r2;
    for (int i = 0; i < NUM_AX; i++) begin
      psum[i] = sext33(rt.pair.p[i]) + sext33(rt.pair.q[i]);
      base_next.neg[i] = rt.pair.vneg[i] != drneg;
    end
    if (first) begin
      base_next.mcase  = CASE_FIRST;
      base_next.center = rt.pair.p;
      base_next.radius = rt.pair.r1;
    end else if (c2) begin
      base_next.mcase  = CASE_SECOND;
      base_next.center = rt.pair.q;
      base_next.radius = rt.pair.r2;
    end else begin
      base_next.mcase = CASE_MERGE;
      for (int i = 0; i < NUM_AX; i++) begin
        base_next.center[i] = psum[i][MAG_W-1:1];
      end
      // saturate the halved sum to the radius range
      base_next.radius = (|rsum[ROOT_W+1:RAD_W+1]) ? '1 : rsum[RAD_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (sd_ready) begin
      sd_base  <= base_next;
      sd_mag   <= rt.pair.mag;
      sd_d     <= rt.root;
      sd_drmag <= drneg ? (rt.pair.r1 - rt.pair.r2) : (rt.pair.r2 - rt.pair.r1);
    end
  end

  // multiply |q - p| by |r2 - r1| and seed the divider with 2d
  logic [PROD_W-1:0] prod [NUM_AX];

  always_comb begin
    for (int i = 0; i < NUM_AX; i++) begin
      prod[i] = sd_mag[i] * sd_drmag;
    end
  end

  always_ff @(posedge clk) begin
    if (sm_ready) begin
      for (int i = 0; i < NUM_AX; i++) begin
        sm_data.lane[i].rem <= DREM_W'(prod[i][PROD_W-1:QUO_W]);
        sm_data.lane[i].num <= prod[i][QUO_W-1:0];
        sm_data.lane[i].quo <= '0;
      end
      sm_data.divisor <= {sd_d, 1'b0};
      sm_data.base    <= sd_base;
    end
  end

  assign dc_data[0]  = sm_data;
  assign dc_valid[0] = sm_valid;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    tsbm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dc_valid[k]),
      .in_ready  (dc_ready[k]),
      .in_data   (dc_data[k]),
      .out_valid (dc_valid[k+1]),
      .out_ready (dc_ready[k+1]),
      .out_data  (dc_data[k+1])
    );
  end

  // merge case: apply the signed offset and saturate; other cases pass the center
  div_t              dt;
  logic [QUO_W+1:0]  off  [NUM_AX];
  logic [QUO_W+1:0]  csum [NUM_AX];
  logic [COORD_W-1:0] cout [NUM_AX];

  always_comb begin
    dt = dc_data[DIV_CELLS];
    for (int i = 0; i < NUM_AX; i++) begin
      off[i]  = dt.base.neg[i] ? -((QUO_W+2)'(dt.lane[i].quo))
                               : (QUO_W+2)'(dt.lane[i].quo);
      csum[i] = {{3{dt.base.center[i][COORD_W-1]}}, dt.base.center[i]} + off[i];
      if (dt.base.mcase != CASE_MERGE) begin
        cout[i] = dt.base.center[i];
      end else if (!csum[i][QUO_W+1] && (|csum[i][QUO_W:COORD_W-1])) begin
        cout[i] = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (csum[i][QUO_W+1] && !(&csum[i][QUO_W:COORD_W-1])) begin
        cout[i] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        cout[i] = csum[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sf_ready) begin
      m_tdata <= {1'b0, dt.base.radius, cout[2], cout[1], cout[0]};
      m_tuser <= dt.base.mcase;
    end
  end

endmodule
